### sv/at_command_line_parser_defines.svh
// ---------------------------------------------------------------------------
// AT command line parser assertion macros
// Wrappers for concurrent assertions on the parser logic.
// ---------------------------------------------------------------------------
`ifndef AT_COMMAND_LINE_PARSER_DEFINES_SVH
`define AT_COMMAND_LINE_PARSER_DEFINES_SVH

// same-cycle implication
`define AT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/atclp_pkg.sv
// ---------------------------------------------------------------------------
// AT command line parser package
// Character codes, byte classes, parser phases and the queue entry type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package atclp_pkg;

   localparam int          NAME_MAX_CHARS_DEFAULT = 7;
   localparam int          NAME_BITS_WIDE         = 64;
   localparam int          NAME_FIELD_BITS        = 56;
   localparam logic [5:0]  LINE_LENGTH_RESET      = 6'd20;

   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
   localparam logic [7:0]  CHAR_EQUAL = 8'h3D;
   localparam logic [7:0]  CHAR_QUERY = 8'h3F;
   localparam logic [7:0]  CHAR_UA    = 8'h41;
   localparam logic [7:0]  CHAR_LA    = 8'h61;
   localparam logic [7:0]  CHAR_UT    = 8'h54;
   localparam logic [7:0]  CHAR_LT    = 8'h74;

   typedef enum logic [3:0] {
      CLS_A,
      CLS_T,
      CLS_PLUS,
      CLS_QUERY,
      CLS_EQUAL,
      CLS_CR,
      CLS_LF,
      CLS_NUL,
      CLS_OTHER
   } byte_class_type;

   typedef enum logic [2:0] {
      PH_A,
      PH_T,
      PH_PLUS,
      PH_NAME,
      PH_PEND,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_QUERY,
      PEND_EQUAL,
      PEND_CR
   } pending_type;

   typedef enum logic [1:0] {
      MODE_RUN,
      MODE_READ,
      MODE_TEST,
      MODE_SET
   } mode_type;

   typedef struct packed {
      logic [7:0]     rx_byte;
      byte_class_type cls;
   } queue_entry_type;

endpackage

### sv/atclp_if.sv
// ---------------------------------------------------------------------------
// AT command line parser channels
// Valid/ready channels for received bytes and for parse results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atclp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  echo_byte;
   logic        line_end;
   logic        line_ok;
   logic [1:0]  command_mode;
   logic [55:0] command_name;
   logic [2:0]  name_length;

   modport source (output valid, output echo_byte, output line_end, output line_ok,
                   output command_mode, output command_name, output name_length,
                   input ready);
   modport sink   (input valid, input echo_byte, input line_end, input line_ok,
                   input command_mode, input command_name, input name_length,
                   output ready);
endinterface

### sv/atclp_front.sv
// ---------------------------------------------------------------------------
// AT command line parser front end
// Accept received bytes, classify them and push them into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atclp_front (
   atclp_req_if.sink                 req_bus,
   output logic                      push_valid,
   output atclp_pkg::queue_entry_type push_entry,
   input  logic                      push_ready
);

   function automatic atclp_pkg::byte_class_type classify(input logic [7:0] b);
      atclp_pkg::byte_class_type c;
      case (b)
         atclp_pkg::CHAR_UA,
         atclp_pkg::CHAR_LA:    c = atclp_pkg::CLS_A;
         atclp_pkg::CHAR_UT,
         atclp_pkg::CHAR_LT:    c = atclp_pkg::CLS_T;
         atclp_pkg::CHAR_PLUS:  c = atclp_pkg::CLS_PLUS;
         atclp_pkg::CHAR_QUERY: c = atclp_pkg::CLS_QUERY;
         atclp_pkg::CHAR_EQUAL: c = atclp_pkg::CLS_EQUAL;
         atclp_pkg::CHAR_CR:    c = atclp_pkg::CLS_CR;
         atclp_pkg::CHAR_LF:    c = atclp_pkg::CLS_LF;
         atclp_pkg::CHAR_NUL:   c = atclp_pkg::CLS_NUL;
         default:               c = atclp_pkg::CLS_OTHER;
      endcase
      return c;
   endfunction

   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;
   assign push_entry    = {req_bus.rx_byte, classify(req_bus.rx_byte)};

endmodule

### sv/atclp_queue.sv
// ---------------------------------------------------------------------------
// AT command line parser queue
// Two-beat queue between the classifier and the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atclp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  atclp_pkg::queue_entry_type push_entry,
   output logic                       push_ready,
   output logic                       pop_valid,
   output atclp_pkg::queue_entry_type pop_entry,
   input  logic                       pop_ready
);

   localparam logic [1:0] Depth = 2'd2;

   atclp_pkg::queue_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != Depth);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/atclp_back.sv
// ---------------------------------------------------------------------------
// AT command line parser back end
// Run the line parser one byte per cycle while the result register is free or being taken, and hold the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "at_command_line_parser_defines.svh"

module atclp_back #(
   parameter int NAME_MAX_CHARS = atclp_pkg::NAME_MAX_CHARS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   input  atclp_pkg::queue_entry_type pop_entry,
   output logic                       pop_ready,
   input  logic                       csr_write_enable,
   input  logic [5:0]                 csr_write_data,
   atclp_rsp_if.source                rsp_bus
);

   localparam int CountWidth = $clog2(NAME_MAX_CHARS + 1);
   localparam int NameBits   = 8 * NAME_MAX_CHARS;

   // configuration
   logic [5:0] max_len_ff, max_len_in;

   // parser state
   logic [5:0]                 pos_ff, pos_in;
   atclp_pkg::phase_type       phase_ff, phase_in;
   atclp_pkg::pending_type     pend_ff, pend_in;
   atclp_pkg::mode_type        mode_ff, mode_in;
   logic                       err_ff, err_in;
   logic [NAME_MAX_CHARS-1:0][7:0] name_ff, name_in;
   logic [CountWidth-1:0]      count_ff, count_in;

   // parse of the current byte, before any line clear
   atclp_pkg::phase_type       p_phase;
   atclp_pkg::pending_type     p_pend;
   atclp_pkg::mode_type        p_mode;
   logic                       p_err;
   logic [NAME_MAX_CHARS-1:0][7:0] p_name;
   logic [CountWidth-1:0]      p_count;

   // result beat
   logic        valid_ff, valid_in;
   logic [7:0]  echo_ff, echo_in;
   logic        end_ff, end_in;
   logic        ok_ff, ok_in;
   logic [1:0]  cmode_ff, cmode_in;
   logic [55:0] cname_ff, cname_in;
   logic [2:0]  nlen_ff, nlen_in;

   logic                  pop;
   logic                  overflow;
   logic                  clear_line;
   logic [atclp_pkg::NAME_BITS_WIDE-1:0] name_wide;
   atclp_pkg::byte_class_type cls;

   assign cls       = pop_entry.cls;
   assign pop_ready = !valid_ff || rsp_bus.ready;
   assign pop       = pop_valid && pop_ready;
   assign overflow  = (pos_ff >= max_len_ff);

   // next parse state: phase, pending terminator, mode, error flag, name and count
   always_comb begin
      p_phase = phase_ff;
      p_pend  = pend_ff;
      p_mode  = mode_ff;
      p_err   = err_ff;
      p_name  = name_ff;
      p_count = count_ff;
      if (!err_ff) begin
         case (phase_ff)
            atclp_pkg::PH_A: begin
               if (cls == atclp_pkg::CLS_A) p_phase = atclp_pkg::PH_T;
               else                         p_err   = 1'b1;
            end
            atclp_pkg::PH_T: begin
               if (cls == atclp_pkg::CLS_T) p_phase = atclp_pkg::PH_PLUS;
               else                         p_err   = 1'b1;
            end
            atclp_pkg::PH_PLUS: begin
               if (cls == atclp_pkg::CLS_PLUS) p_phase = atclp_pkg::PH_NAME;
               else                            p_err   = 1'b1;
            end
            atclp_pkg::PH_NAME: begin
               if (cls == atclp_pkg::CLS_NUL) begin
                  p_err = 1'b1;
               end else if (cls == atclp_pkg::CLS_QUERY) begin
                  p_pend  = atclp_pkg::PEND_QUERY;
                  p_phase = atclp_pkg::PH_PEND;
               end else if (cls == atclp_pkg::CLS_EQUAL) begin
                  p_pend  = atclp_pkg::PEND_EQUAL;
                  p_phase = atclp_pkg::PH_PEND;
               end else if (cls == atclp_pkg::CLS_CR) begin
                  p_pend  = atclp_pkg::PEND_CR;
                  p_phase = atclp_pkg::PH_PEND;
               end else if (count_ff >= CountWidth'(NAME_MAX_CHARS)) begin
                  p_err = 1'b1;
               end else begin
                  for (int i = 0; i < NAME_MAX_CHARS; i++) begin
                     if (count_ff == CountWidth'(i)) p_name[i] = pop_entry.rx_byte;
                  end
                  p_count = count_ff + CountWidth'(1);
               end
            end
            atclp_pkg::PH_PEND: begin
               case (pend_ff)
                  atclp_pkg::PEND_QUERY: begin
                     if (cls == atclp_pkg::CLS_CR) begin
                        p_mode  = atclp_pkg::MODE_READ;
                        p_phase = atclp_pkg::PH_DONE;
                     end else begin
                        p_err = 1'b1;
                     end
                  end
                  atclp_pkg::PEND_EQUAL: begin
                     if (cls == atclp_pkg::CLS_QUERY) begin
                        p_mode  = atclp_pkg::MODE_TEST;
                        p_phase = atclp_pkg::PH_DONE;
                     end else if (cls == atclp_pkg::CLS_CR || cls == atclp_pkg::CLS_NUL) begin
                        p_err = 1'b1;
                     end else begin
                        p_mode  = atclp_pkg::MODE_SET;
                        p_phase = atclp_pkg::PH_DONE;
                     end
                  end
                  atclp_pkg::PEND_CR: begin
                     if (cls == atclp_pkg::CLS_LF) begin
                        p_mode  = atclp_pkg::MODE_RUN;
                        p_phase = atclp_pkg::PH_DONE;
                     end else begin
                        p_err = 1'b1;
                     end
                  end
                  default: p_err = 1'b1;
               endcase
            end
            atclp_pkg::PH_DONE: begin
            end
            default: p_err = 1'b1;
         endcase
      end
   end

   // result fields and line clearing
   always_comb begin
      name_wide  = atclp_pkg::NAME_BITS_WIDE'(NameBits'(p_name));
      echo_in    = pop_entry.rx_byte;
      end_in     = overflow || (cls == atclp_pkg::CLS_LF);
      ok_in      = !overflow && (cls == atclp_pkg::CLS_LF) && !p_err
                   && (p_phase == atclp_pkg::PH_DONE);
      cmode_in   = ok_in ? p_mode : 2'd0;
      cname_in   = ok_in ? name_wide[atclp_pkg::NAME_FIELD_BITS-1:0] : 56'd0;
      nlen_in    = ok_in ? 3'(p_count) : 3'd0;
      clear_line = end_in;
   end

   // register next values
   always_comb begin
      max_len_in = csr_write_enable ? csr_write_data : max_len_ff;
      valid_in   = pop ? 1'b1 : (rsp_bus.ready ? 1'b0 : valid_ff);
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      mode_in    = mode_ff;
      err_in     = err_ff;
      name_in    = name_ff;
      count_in   = count_ff;
      if (pop) begin
         if (clear_line) begin
            pos_in   = 6'd0;
            phase_in = atclp_pkg::PH_A;
            pend_in  = atclp_pkg::PEND_NONE;
            mode_in  = atclp_pkg::MODE_RUN;
            err_in   = 1'b0;
            name_in  = '0;
            count_in = '0;
         end else begin
            pos_in   = pos_ff + 6'd1;
            phase_in = p_phase;
            pend_in  = p_pend;
            mode_in  = p_mode;
            err_in   = p_err;
            name_in  = p_name;
            count_in = p_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= atclp_pkg::LINE_LENGTH_RESET;
         valid_ff   <= 1'b0;
         pos_ff     <= 6'd0;
         phase_ff   <= atclp_pkg::PH_A;
         pend_ff    <= atclp_pkg::PEND_NONE;
         mode_ff    <= atclp_pkg::MODE_RUN;
         err_ff     <= 1'b0;
         name_ff    <= '0;
         count_ff   <= '0;
      end else begin
         max_len_ff <= max_len_in;
         valid_ff   <= valid_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         mode_ff    <= mode_in;
         err_ff     <= err_in;
         name_ff    <= name_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         echo_ff  <= echo_in;
         end_ff   <= end_in;
         ok_ff    <= ok_in;
         cmode_ff <= cmode_in;
         cname_ff <= cname_in;
         nlen_ff  <= nlen_in;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.echo_byte    = echo_ff;
   assign rsp_bus.line_end     = end_ff;
   assign rsp_bus.line_ok      = ok_ff;
   assign rsp_bus.command_mode = cmode_ff;
   assign rsp_bus.command_name = cname_ff;
   assign rsp_bus.name_length  = nlen_ff;

   `AT_ASSERT_NEXT(a_overflow_aborts, clock, reset, pop && overflow,
      rsp_bus.valid && rsp_bus.line_end && !rsp_bus.line_ok, "overflow beat did not abort line")
   `AT_ASSERT_NEXT(a_line_end_clears, clock, reset, pop && end_in,
      pos_ff == 6'd0 && phase_ff == atclp_pkg::PH_A && !err_ff, "line end left parser state")
   `AT_ASSERT_NEXT(a_error_sticks, clock, reset, err_ff,
      err_ff || pos_ff == 6'd0, "error flag dropped inside a line")
   `AT_ASSERT_SAME(a_ok_needs_end, clock, reset, rsp_bus.valid && rsp_bus.line_ok,
      rsp_bus.line_end && rsp_bus.echo_byte == atclp_pkg::CHAR_LF, "line_ok without LF line end")

endmodule

### sv/at_command_line_parser.sv
// ---------------------------------------------------------------------------
// AT command line parser
// Echo serial bytes and parse "AT+name" command lines into name and mode.
// ---------------------------------------------------------------------------
// Each byte accepted on req_bus produces exactly one result beat on rsp_bus,
// carrying the byte unchanged plus the line verdict when the byte ends the
// line (LF, or any byte once max_line_length bytes have been taken). The
// block sustains one byte per clock while rsp_bus takes each result beat:
// the parser in the back end then retires one byte per cycle, and each
// result passes through the two-beat queue and then the result register.
// The queue lets input keep flowing while a result beat waits to be taken.
// csr_write_data sets max_line_length (reset 20); write it only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module at_command_line_parser #(
   parameter int NAME_MAX_CHARS = atclp_pkg::NAME_MAX_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   atclp_req_if.sink   req_bus,
   atclp_rsp_if.source rsp_bus,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);

   // classified beats from front to queue
   logic                       push_valid;
   logic                       push_ready;
   atclp_pkg::queue_entry_type push_entry;

   // queued beats from queue to parser
   logic                       pop_valid;
   logic                       pop_ready;
   atclp_pkg::queue_entry_type pop_entry;

   // Classify each byte as it arrives; hold ready low only when the queue is full.
   atclp_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // Decouple the classifier from the parser so each side can stall alone.
   atclp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // Advance the line parser and drive the registered result beat.
   atclp_back #(
      .NAME_MAX_CHARS (NAME_MAX_CHARS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_entry        (pop_entry),
      .pop_ready        (pop_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_bus          (rsp_bus)
   );

endmodule

### tb/at_command_line_parser_tb.sv
// ---------------------------------------------------------------------------
// AT command line parser testbench
// Sends directed and random command lines byte by byte under several line
// length limits, predicts each result beat and checks it field by field,
// with random gaps on the byte side and random stalls on the result side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module at_command_line_parser_tb;
   import atclp_pkg::*;

   localparam int NAME_LIMIT   = NAME_MAX_CHARS_DEFAULT;
   localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 10;     // drain margin once no beat is owed

   typedef struct packed {
      logic [7:0]  echo_byte;
      logic        line_end;
      logic        line_ok;
      mode_type    command_mode;
      logic [55:0] command_name;
      logic [2:0]  name_length;
   } parse_result_type;

   typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, PERIODIC} stall_style_type;

   // Line parser mirror plus the queue of result beats still owed by the block.
   class parse_scoreboard;
      logic [5:0]                max_length;
      logic [5:0]                position;
      phase_type                 phase;
      pending_type               pending;
      mode_type                  mode;
      bit                        line_failed;
      logic [NAME_BITS_WIDE-1:0] name;
      int                        count;
      parse_result_type          owed[$];
      int                        failures;
      int                        bytes_seen;
      int                        lines_ended;
      int                        mode_hits[4];

      function new();
         max_length = LINE_LENGTH_RESET;
         clear_line();
      endfunction

      function void clear_line();
         position    = '0;
         phase       = PH_A;
         pending     = PEND_NONE;
         mode        = MODE_RUN;
         line_failed = 1'b0;
         name        = '0;
         count       = 0;
      endfunction

      function void advance(logic [7:0] b);
         case (phase)
            PH_A: begin
               if (b == CHAR_UA || b == CHAR_LA) phase = PH_T;
               else line_failed = 1'b1;
            end
            PH_T: begin
               if (b == CHAR_UT || b == CHAR_LT) phase = PH_PLUS;
               else line_failed = 1'b1;
            end
            PH_PLUS: begin
               if (b == CHAR_PLUS) phase = PH_NAME;
               else line_failed = 1'b1;
            end
            PH_NAME: begin
               if (b == CHAR_NUL) begin
                  line_failed = 1'b1;
               end else if (b == CHAR_QUERY) begin
                  pending = PEND_QUERY;
                  phase   = PH_PEND;
               end else if (b == CHAR_EQUAL) begin
                  pending = PEND_EQUAL;
                  phase   = PH_PEND;
               end else if (b == CHAR_CR) begin
                  pending = PEND_CR;
                  phase   = PH_PEND;
               end else if (count >= NAME_LIMIT || count >= 8) begin
                  line_failed = 1'b1;
               end else begin
                  name[8*count +: 8] = b;
                  count++;
               end
            end
            PH_PEND: begin
               case (pending)
                  PEND_QUERY: begin
                     if (b == CHAR_CR) begin
                        mode  = MODE_READ;
                        phase = PH_DONE;
                     end else line_failed = 1'b1;
                  end
                  PEND_EQUAL: begin
                     if (b == CHAR_QUERY) begin
                        mode  = MODE_TEST;
                        phase = PH_DONE;
                     end else if (b == CHAR_CR || b == CHAR_NUL) begin
                        line_failed = 1'b1;
                     end else begin
                        mode  = MODE_SET;
                        phase = PH_DONE;
                     end
                  end
                  PEND_CR: begin
                     if (b == CHAR_LF) begin
                        mode  = MODE_RUN;
                        phase = PH_DONE;
                     end else line_failed = 1'b1;
                  end
                  default: line_failed = 1'b1;
               endcase
            end
            PH_DONE: ;
            default: line_failed = 1'b1;
         endcase
      endfunction

      function void note_byte(logic [7:0] b);
         parse_result_type want;
         want           = '0;
         want.echo_byte = b;
         bytes_seen++;
         if (position >= max_length) begin
            want.line_end = 1'b1;
            clear_line();
         end else begin
            position++;
            if (!line_failed) advance(b);
            if (b == CHAR_LF) begin
               want.line_end = 1'b1;
               if (!line_failed && phase == PH_DONE) begin
                  want.line_ok      = 1'b1;
                  want.command_mode = mode;
                  want.command_name = name[55:0];
                  want.name_length  = count[2:0];
                  mode_hits[mode]++;
               end
               clear_line();
            end
         end
         if (want.line_end) lines_ended++;
         owed.push_back(want);
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type want;
         if (owed.size() == 0) begin
            $error("result beat with nothing outstanding, echo_byte %h", got.echo_byte);
            failures++;
            return;
         end
         want = owed.pop_front();
         if (got.echo_byte !== want.echo_byte) begin
            $error("echo_byte mismatch: expected %h, actual %h",
                   want.echo_byte, got.echo_byte);
            failures++;
         end
         if (got.line_end !== want.line_end) begin
            $error("line_end mismatch: expected %b, actual %b", want.line_end, got.line_end);
            failures++;
         end
         if (got.line_ok !== want.line_ok) begin
            $error("line_ok mismatch: expected %b, actual %b", want.line_ok, got.line_ok);
            failures++;
         end
         if (got.command_mode !== want.command_mode) begin
            $error("command_mode mismatch: expected %0d, actual %0d",
                   want.command_mode, got.command_mode);
            failures++;
         end
         if (got.command_name !== want.command_name) begin
            $error("command_name mismatch: expected %h, actual %h",
                   want.command_name, got.command_name);
            failures++;
         end
         if (got.name_length !== want.name_length) begin
            $error("name_length mismatch: expected %0d, actual %0d",
                   want.name_length, got.name_length);
            failures++;
         end
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            csr_write_enable;
   logic [5:0]      csr_write_data;

   atclp_req_if     req_bus ();
   atclp_rsp_if     rsp_bus ();

   parse_scoreboard  board = new();
   parse_result_type seen;
   int               burst_left;
   int               quiet_cycles;
   int               settings_used;
   stall_style_type  stall_style;
   int               style_left;
   int               style_tick;

   at_command_line_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Result side: pick a stall style for a random stretch, then hold ready
   // to that style. Stretches of ALWAYS_READY give runs with no stall at all.
   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         style_left  = $urandom_range(30, 150);
      end else begin
         style_left--;
      end
      style_tick++;
      case (stall_style)
         ALWAYS_READY:   rsp_bus.ready <= 1'b1;
         COIN_FLIP:      rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         MOSTLY_STALLED: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:        rsp_bus.ready <= ((style_tick % 7) < 3);
      endcase
   end

   // Check every result beat taken at a rising edge against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.echo_byte    = rsp_bus.echo_byte;
         seen.line_end     = rsp_bus.line_end;
         seen.line_ok      = rsp_bus.line_ok;
         seen.command_mode = mode_type'(rsp_bus.command_mode);
         seen.command_name = rsp_bus.command_name;
         seen.name_length  = rsp_bus.name_length;
         board.check_result(seen);
      end
   end

   // Send one byte. Bursts of random length are separated by random gaps;
   // valid stays high across the beats of a burst.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_byte(b);
   endtask

   // Send a text line; a tilde stands for CR so directed lines stay readable.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte((s[i] == "~") ? CHAR_CR : s[i]);
   endtask

   // Any byte that can sit inside a name without ending or terminating it.
   function automatic logic [7:0] name_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CHAR_QUERY || c == CHAR_EQUAL || c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   // Half the time one of a list of special and extreme byte values, else any byte.
   function automatic logic [7:0] noise_byte();
      logic [7:0] picks[10];
      picks = '{CHAR_NUL, CHAR_LF, CHAR_CR, CHAR_PLUS, CHAR_EQUAL, CHAR_QUERY,
                CHAR_UA, CHAR_LT, 8'hFF, 8'h80};
      if ($urandom_range(0, 1) == 1) return picks[$urandom_range(0, 9)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly well-formed commands with random content; some get one byte
   // replaced, dropped or inserted; the rest is plain noise up to an LF.
   task automatic send_random_line();
      logic [7:0] line[$];
      int         kind;
      int         spot;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         line.push_back(($urandom_range(0, 1) == 1) ? CHAR_UA : CHAR_LA);
         line.push_back(($urandom_range(0, 1) == 1) ? CHAR_UT : CHAR_LT);
         line.push_back(CHAR_PLUS);
         repeat ($urandom_range(0, NAME_LIMIT + ((kind >= 65) ? 1 : 0)))
            line.push_back(name_char());
         case (mode_type'($urandom_range(0, 3)))
            MODE_RUN:  line.push_back(CHAR_CR);
            MODE_READ: begin
               line.push_back(CHAR_QUERY);
               line.push_back(CHAR_CR);
            end
            MODE_TEST: begin
               line.push_back(CHAR_EQUAL);
               line.push_back(CHAR_QUERY);
            end
            default: begin
               line.push_back(CHAR_EQUAL);
               repeat ($urandom_range(1, 4)) line.push_back(name_char());
            end
         endcase
         // trailing bytes after the mode is settled are ignored up to LF
         if (line[line.size() - 1] != CHAR_CR)
            repeat ($urandom_range(0, 2)) line.push_back(name_char());
         line.push_back(CHAR_LF);
         if (kind >= 65) begin
            spot = $urandom_range(0, line.size() - 2);
            case ($urandom_range(0, 2))
               0:       line[spot] = noise_byte();
               1:       line.delete(spot);
               default: line.insert(spot, noise_byte());
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 10)) line.push_back(noise_byte());
         line.push_back(CHAR_LF);
      end
      foreach (line[i]) send_byte(line[i]);
   endtask

   task automatic send_random_lines(input int budget);
      int start;
      start = board.bytes_seen;
      while (board.bytes_seen - start < budget) send_random_line();
   endtask

   // Drop valid, let every owed beat drain, then write the line length limit.
   task automatic write_max_length(input logic [5:0] value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.max_length = value;
      settings_used++;
   endtask

   // Abort the run if nothing moves on either side for too long.
   initial begin
      @(negedge reset);
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("at_command_line_parser test failed");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = '0;
      rsp_bus.ready    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines under the reset limit of 20: each mode, case mixes
      send_text("AT+CSQ~\n");
      send_text("at+cgmi?~\n");
      send_text("At+CMGF=?\n");
      send_text("aT+CMGF=1\n");
      // equal sign then LF is a set, and that LF ends the line
      send_text("AT+X=\n");
      // bytes after the mode is settled are ignored
      send_text("AT+V=?xyz\n");
      // longest name, then one character too many
      send_text("AT+ABCDEFG~\n");
      send_text("AT+ABCDEFGH~\n");
      // name never terminated
      send_text("AT+ABC\n");
      // NUL inside the name and right after the equal sign
      send_text("AT+AB");
      send_byte(CHAR_NUL);
      send_text("C~\n");
      send_text("AT+A=");
      send_byte(CHAR_NUL);
      send_text("\n");
      // bad terminators: CR after equal, query without CR, CR without LF
      send_text("AT+A=~\n");
      send_text("AT+A?X~\n");
      send_text("AT+A~X\n");
      // short and wrong prefixes
      send_text("AT\n");
      send_text("\n");
      send_text("BT+A~\n");
      send_text("AX+A~\n");
      send_text("AT-A~\n");
      // empty names
      send_text("AT+~\n");
      send_text("AT+?~\n");
      // extreme byte values in the name and as the set argument
      send_text("AT+");
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(CHAR_EQUAL);
      send_byte(8'hFE);
      send_text("\n");
      // exactly 20 bytes fits; with one more the LF itself overflows
      send_text("AT+ABCDEFG=12345678\n");
      send_text("AT+ABCDEFG=123456789\n");
      // overflow mid-line: the 21st byte aborts, then a fresh line follows
      send_text("AT+Q=xxxxxxxxxxxxxxx!AT+R~\n");

      // Widest limit: a 63-byte line fits, a 64-byte one overflows on LF
      write_max_length(6'd63);
      send_text("AT+LONG=");
      repeat (54) send_byte("x");
      send_byte(CHAR_LF);
      send_text("AT+LONG=");
      repeat (55) send_byte("x");
      send_byte(CHAR_LF);

      // Zero limit: every byte aborts
      write_max_length(6'd0);
      repeat (12) send_byte(noise_byte());

      write_max_length(6'd1);
      send_text("A\nAT\n");

      // Four is too short for any command, five just fits "AT+" CR LF
      write_max_length(6'd4);
      send_random_lines(25);
      write_max_length(6'd5);
      send_text("AT+~\n");
      send_random_lines(25);

      // Random limits, then back to the extremes and the reset value
      repeat (4) begin
         write_max_length($urandom_range(6, 40));
         send_random_lines(30);
      end
      write_max_length(6'd63);
      send_random_lines(20);
      write_max_length(LINE_LENGTH_RESET);
      send_random_lines(20);

      // Drain: hold valid low, wait for every owed beat, then a margin
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes, %0d line ends, under %0d written line limits",
               board.bytes_seen, board.lines_ended, settings_used);
      $display("Valid commands by mode: run %0d, read %0d, test %0d, set %0d",
               board.mode_hits[MODE_RUN], board.mode_hits[MODE_READ],
               board.mode_hits[MODE_TEST], board.mode_hits[MODE_SET]);
      if (board.failures == 0 && board.outstanding() == 0)
         $display("at_command_line_parser test passed");
      else
         $display("at_command_line_parser test failed");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/atclp_pkg.sv
sv/atclp_if.sv
sv/atclp_front.sv
sv/atclp_queue.sv
sv/atclp_back.sv
sv/at_command_line_parser.sv
tb/at_command_line_parser_tb.sv
